// ----- rtl/chsbs_pkg.sv -----
// Shared types, constants and tables of the cosine hemisphere bounce sampler.
package chsbs_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int DRAW_WIDTH       = 16;
  localparam int FRAC_BITS        = COORD_WIDTH - 2;
  localparam int REFL_BITS        = 16;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int MAX_ANGLE_STAGES = 32;

  // angle datapath, Q2.30 with headroom
  localparam int ANG_W = 34;
  // square root lanes: operand below 2^61
  localparam int ROOT_W     = 62;
  localparam int ROOT_STEPS = 31;
  localparam int ROOT_OUT_W = 31;
  // colour division
  localparam int SUM_W  = REFL_BITS + 2;
  localparam int DIV_W  = FRAC_BITS + REFL_BITS + 3;
  localparam int QUO_W  = COORD_WIDTH;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0]             HALF_PI_Q30     = 31'd1686629713;

  localparam logic [29:0] ATAN_Q30 [MAX_ANGLE_STAGES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // quadrant codes of the angle draw
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [ROOT_W-1:0] v;
    logic [ROOT_W-1:0] r;
  } root_lane_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_lane_t;

  // one request as it travels the cell chain
  typedef struct packed {
    logic                          live;
    logic [1:0]                    quad;
    logic [2:0][COORD_WIDTH-1:0]   t;
    logic [2:0][COORD_WIDTH:0]     n;
    root_lane_t [1:0]              root;   // 0: radius, 1: height
    div_lane_t [2:0]               div;
    logic [SUM_W-1:0]              sum;
    logic signed [ANG_W-1:0]       x;
    logic signed [ANG_W-1:0]       y;
    logic signed [ANG_W-1:0]       z;
  } item_t;

endpackage

// ----- rtl/chsbs_root_cell.sv -----
// One digit step of the two bitwise square root lanes.
module chsbs_root_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  chsbs_pkg::item_t in_item,
  output logic            out_vld,
  output chsbs_pkg::item_t out_item
);
  import chsbs_pkg::*;

  localparam int BW = ROOT_W + 1;
  localparam logic [BW-1:0] BITV = BW'(1) << (2 * STEP);

  item_t         item_next;
  logic [BW-1:0] trial;

  always_comb begin
    item_next = in_item;
    trial     = '0;
    for (int l = 0; l < 2; l++) begin
      trial = {1'b0, in_item.root[l].r} + BITV;
      if ({1'b0, in_item.root[l].v} >= trial) begin
        item_next.root[l].v = in_item.root[l].v - trial[ROOT_W-1:0];
        item_next.root[l].r = (in_item.root[l].r >> 1) + BITV[ROOT_W-1:0];
      end else begin
        item_next.root[l].r = in_item.root[l].r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/chsbs_div_cell.sv -----
// One quotient bit of the three colour division lanes.
module chsbs_div_cell #(
  parameter int QBIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  chsbs_pkg::item_t in_item,
  output logic            out_vld,
  output chsbs_pkg::item_t out_item
);
  import chsbs_pkg::*;

  item_t            item_next;
  logic [DIV_W-1:0] dsh;

  assign dsh = DIV_W'(in_item.sum) << QBIT;

  always_comb begin
    item_next = in_item;
    for (int c = 0; c < 3; c++) begin
      if (in_item.div[c].rem >= dsh) begin
        item_next.div[c].rem       = in_item.div[c].rem - dsh;
        item_next.div[c].quo[QBIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/chsbs_cordic_cell.sv -----
// One rotation step of the angle unit.
module chsbs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  chsbs_pkg::item_t in_item,
  output logic            out_vld,
  output chsbs_pkg::item_t out_item
);
  import chsbs_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = $signed({4'b0, ATAN_Q30[STAGE]});

  item_t                   item_next;
  logic signed [ANG_W-1:0] dx;
  logic signed [ANG_W-1:0] dy;

  assign dx = in_item.y >>> STAGE;
  assign dy = in_item.x >>> STAGE;

  always_comb begin
    item_next = in_item;
    if (!in_item.z[ANG_W-1]) begin
      item_next.x = in_item.x - dx;
      item_next.y = in_item.y + dy;
      item_next.z = in_item.z - ATAN;
    end else begin
      item_next.x = in_item.x + dx;
      item_next.y = in_item.y - dy;
      item_next.z = in_item.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/chsbs_frame.sv -----
// Frame transform, rounding, saturation and output register.
module chsbs_frame (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  chsbs_pkg::item_t                     in_item,
  output logic                                out_vld,
  output logic                                alive,
  output logic [2:0][chsbs_pkg::COORD_WIDTH-1:0] dir,
  output logic [2:0][chsbs_pkg::COORD_WIDTH-1:0] color
);
  import chsbs_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = COORD_WIDTH + 1;
  localparam int PW = NW + CW;
  localparam int AW = 54;
  localparam logic signed [AW-1:0] HALF_LSB = AW'(64'sd1 << 27);
  localparam logic signed [25:0] VMAX = 26'sd32767;
  localparam logic signed [25:0] VMIN = -26'sd32768;

  // stage 1
  logic signed [ANG_W-1:0] cs, sn;
  logic signed [31:0]      sr;
  logic                    p1_vld, p1_live;
  logic signed [65:0]      p1_cprod, p1_sprod;
  logic [28:0]             p1_z28;
  logic signed [PW-1:0]    p1_nt [3][2];
  logic [2:0][CW-1:0]      p1_t, p1_col;
  logic [2:0][NW-1:0]      p1_n;
  // stage 2
  logic                    p2_vld, p2_live;
  logic signed [31:0]      p2_cx, p2_sy;
  logic signed [29:0]      p2_z;
  logic signed [19:0]      p2_cr [3];
  logic signed [PW:0]      diff [3];
  logic [2:0][CW-1:0]      p2_t, p2_col;
  logic [2:0][NW-1:0]      p2_n;
  // stage 3
  logic                    p3_vld, p3_live;
  logic signed [47:0]      p3_mt [3];
  logic signed [51:0]      p3_mc [3];
  logic signed [46:0]      p3_mn [3];
  logic [2:0][CW-1:0]      p3_col;
  // final
  logic signed [AW-1:0]    acc [3];
  logic signed [25:0]      vr [3];
  logic [2:0][CW-1:0]      vsat;
  logic                    nonzero, alive_next;

  always_comb begin
    unique case (in_item.quad)
      QUAD_0: begin cs = in_item.x;  sn = in_item.y;  end
      QUAD_1: begin cs = -in_item.y; sn = in_item.x;  end
      QUAD_2: begin cs = -in_item.x; sn = -in_item.y; end
      QUAD_3: begin cs = in_item.y;  sn = -in_item.x; end
      default: begin cs = in_item.x; sn = in_item.y;  end
    endcase
  end

  assign sr = $signed({1'b0, in_item.root[0].r[ROOT_OUT_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= in_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      out_vld <= p3_vld;
    end
  end

  // stage 1: scale cos/sin by the radius, cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      p1_live  <= in_item.live;
      p1_cprod <= cs * sr;
      p1_sprod <= sn * sr;
      p1_z28   <= in_item.root[1].r[ROOT_OUT_W-1:2];
      p1_t     <= in_item.t;
      p1_n     <= in_item.n;
      for (int i = 0; i < 3; i++) begin
        p1_nt[i][0] <= $signed(in_item.n[(i+1)%3]) * $signed(in_item.t[(i+2)%3]);
        p1_nt[i][1] <= $signed(in_item.n[(i+2)%3]) * $signed(in_item.t[(i+1)%3]);
        p1_col[i]   <= in_item.div[i].ovf ? {CW{1'b1}} : in_item.div[i].quo;
      end
    end
  end

  // stage 2: floor to Q2.28 and finish the cross product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = ((PW+1)'(p1_nt[i][0]) >>> 1) - ((PW+1)'(p1_nt[i][1]) >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_live <= p1_live;
      p2_cx   <= p1_cprod[63:32];
      p2_sy   <= p1_sprod[63:32];
      p2_z    <= $signed({1'b0, p1_z28});
      p2_t    <= p1_t;
      p2_n    <= p1_n;
      p2_col  <= p1_col;
      for (int i = 0; i < 3; i++) begin
        p2_cr[i] <= 20'(diff[i] >>> (FRAC_BITS - 1));
      end
    end
  end

  // stage 3: frame products
  always_ff @(posedge clk) begin
    if (en) begin
      p3_live <= p2_live;
      p3_col  <= p2_col;
      for (int i = 0; i < 3; i++) begin
        p3_mt[i] <= $signed(p2_t[i]) * p2_cx;
        p3_mc[i] <= p2_cr[i] * p2_sy;
        p3_mn[i] <= $signed(p2_n[i]) * p2_z;
      end
    end
  end

  // final: sum, round half up, saturate
  always_comb begin
    nonzero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(p3_mt[i]) + AW'(p3_mc[i]) + AW'(p3_mn[i]) + HALF_LSB;
      vr[i]  = 26'(acc[i] >>> 28);
      if (vr[i] > VMAX) begin
        vsat[i] = 16'h7fff;
      end else if (vr[i] < VMIN) begin
        vsat[i] = 16'h8000;
      end else begin
        vsat[i] = vr[i][CW-1:0];
      end
      if (vsat[i] != '0) begin
        nonzero = 1'b1;
      end
    end
    alive_next = p3_live & nonzero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alive <= alive_next;
      dir   <= alive_next ? vsat : '0;
      color <= alive_next ? p3_col : '0;
    end
  end

endmodule

// ----- rtl/cosine_hemisphere_bounce_sampler.sv -----
// Top level of the cosine hemisphere bounce sampler pipeline.
//
// Usage
//   Requests come in on s_tvalid/s_tready/s_tdata: incoming direction,
//   normal, tangent (signed Q2.14 each), packed RGB reflectivity and three
//   packed uniform draws. Each request yields exactly one result on
//   m_tvalid/m_tready/m_tdata/m_tuser: the sampled direction and the
//   normalized colour in m_tdata, and the alive flag in m_tuser.
//   Results leave in request order.
// Throughput and pipeline
//   One request per clock while the output is not stalled. From acceptance
//   to m_tvalid a request passes two front stages, 31 square root cells, 16
//   division cells, ANGLE_STAGES rotation cells, three frame stages and
//   the output register.
// Reset
//   rst (synchronous, active high) empties every stage; no state survives
//   between requests, so no clearing pass is needed.
// Stall
//   The whole chain advances together. When a result sits in the output
//   register and m_tready is low, the chain and s_tready hold; otherwise a
//   request is taken every cycle, also while the output register is full
//   and being drained.
module cosine_hemisphere_bounce_sampler #(
  parameter int ANGLE_STAGES = chsbs_pkg::ANGLE_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // in_dir_x/y/z, normal_x/y/z, tangent_x/y/z (16 b each),
  // reflectivity_rgb (48 b), random_draws (48 b), from bit 0 up
  input  logic [239:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_dir_x/y/z, color_r/g/b (16 b each), from bit 0 up
  output logic [95:0]  m_tdata,
  // alive
  output logic         m_tuser
);
  import chsbs_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int REFL_LSB = 9 * CW;
  localparam int DRAW_LSB = REFL_LSB + 3 * REFL_BITS;
  localparam int DIV_BITS = QUO_W;
  localparam int CHAIN    = ROOT_STEPS + DIV_BITS + ANGLE_STAGES;
  localparam int RSH      = 60 - DRAW_WIDTH;

  logic en;

  // field decode
  logic signed [CW-1:0]   f_dir [3];
  logic signed [CW-1:0]   f_n   [3];
  logic [CW-1:0]          f_t   [3];
  logic [REFL_BITS-1:0]   f_refl[3];
  logic [DRAW_WIDTH-1:0]  d0, d1, d2;
  logic [SUM_W-1:0]       f_sum;
  logic [DIV_W-1:0]       f_num [3];
  logic                   f_ovf [3];
  logic [SUM_W-1:0]       f_d3;

  // front stage 0
  logic                   s0_vld, s0_live;
  logic signed [2*CW-1:0] s0_dot [3];
  logic [44:0]            s0_theta;
  logic [1:0]             s0_quad;
  logic [2:0][CW-1:0]     s0_t;
  logic signed [CW-1:0]   s0_n [3];
  logic [SUM_W-1:0]       s0_sum;
  logic [DIV_W-1:0]       s0_num [3];
  logic                   s0_ovf [3];
  logic [DRAW_WIDTH-1:0]  s0_d2;

  // front stage 1 feeds the chain
  logic signed [2*CW+1:0] dot_sum;
  logic [44:0]            theta_rnd;
  item_t                  item_next;
  logic                   chain_vld  [CHAIN+1];
  item_t                  chain_item [CHAIN+1];

  logic [2:0][CW-1:0]     res_dir, res_col;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_dir[i]  = $signed(s_tdata[CW*i +: CW]);
      f_n[i]    = $signed(s_tdata[CW*(3+i) +: CW]);
      f_t[i]    = s_tdata[CW*(6+i) +: CW];
      f_refl[i] = s_tdata[REFL_LSB + REFL_BITS*(2-i) +: REFL_BITS];
    end
    d0    = s_tdata[DRAW_LSB + 2*DRAW_WIDTH +: DRAW_WIDTH];
    d1    = s_tdata[DRAW_LSB + DRAW_WIDTH +: DRAW_WIDTH];
    d2    = s_tdata[DRAW_LSB +: DRAW_WIDTH];
    f_sum = SUM_W'(f_refl[0]) + SUM_W'(f_refl[1]) + SUM_W'(f_refl[2]);
    f_d3  = SUM_W'(d0) * 2'd3;
    // colour dividend: 3 * channel in Q2.14 plus half the divisor
    for (int i = 0; i < 3; i++) begin
      f_num[i] = DIV_W'({SUM_W'(f_refl[i]) * 2'd3, {FRAC_BITS{1'b0}}})
               + DIV_W'(f_sum >> 1);
      // quotient beyond the field saturates
      f_ovf[i] = {1'b0, f_num[i]} >= {f_sum, {QUO_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // roulette: draw and reflectivity share the same fraction width
      s0_live  <= (f_d3 < f_sum) && (f_sum != '0);
      s0_theta <= 45'(d1[DRAW_WIDTH-3:0]) * 45'(HALF_PI_Q30);
      s0_quad  <= d1[DRAW_WIDTH-1:DRAW_WIDTH-2];
      s0_sum   <= f_sum;
      s0_d2    <= d2;
      for (int i = 0; i < 3; i++) begin
        s0_dot[i] <= f_n[i] * f_dir[i];
        s0_t[i]   <= f_t[i];
        s0_n[i]   <= f_n[i];
        s0_num[i] <= f_num[i];
        s0_ovf[i] <= f_ovf[i];
      end
    end
  end

  // stage 1: turn the normal toward the ray, round the angle, seed lanes
  always_comb begin
    dot_sum   = (2*CW+2)'(s0_dot[0]) + (2*CW+2)'(s0_dot[1]) + (2*CW+2)'(s0_dot[2]);
    theta_rnd = s0_theta + 45'(1 << (DRAW_WIDTH - 3));
    item_next = '0;
    item_next.live = s0_live;
    item_next.quad = s0_quad;
    item_next.t    = s0_t;
    item_next.sum  = s0_sum;
    for (int i = 0; i < 3; i++) begin
      item_next.n[i] = dot_sum[2*CW+1] ? -(CW+1)'(s0_n[i]) : (CW+1)'(s0_n[i]);
      item_next.div[i].rem = s0_num[i];
      item_next.div[i].ovf = s0_ovf[i];
    end
    item_next.root[0].v = ROOT_W'({s0_d2, {RSH{1'b0}}});
    item_next.root[1].v = ROOT_W'({(DRAW_WIDTH+1)'(1 << DRAW_WIDTH)
                                    - (DRAW_WIDTH+1)'(s0_d2), {RSH{1'b0}}});
    item_next.x = CORDIC_GAIN_Q30;
    item_next.y = '0;
    item_next.z = $signed({3'b0, theta_rnd[44:DRAW_WIDTH-2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_vld[0] <= 1'b0;
    end else if (en) begin
      chain_vld[0] <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_item[0] <= item_next;
    end
  end

  // square root cells, most significant digit first
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    chsbs_root_cell #(.STEP(ROOT_STEPS - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (chain_vld[k]),
      .in_item (chain_item[k]),
      .out_vld (chain_vld[k+1]),
      .out_item(chain_item[k+1])
    );
  end

  // colour division cells, one quotient bit each
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    chsbs_div_cell #(.QBIT(DIV_BITS - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (chain_vld[ROOT_STEPS + k]),
      .in_item (chain_item[ROOT_STEPS + k]),
      .out_vld (chain_vld[ROOT_STEPS + k + 1]),
      .out_item(chain_item[ROOT_STEPS + k + 1])
    );
  end

  // rotation cells
  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cordic
    chsbs_cordic_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (chain_vld[ROOT_STEPS + DIV_BITS + k]),
      .in_item (chain_item[ROOT_STEPS + DIV_BITS + k]),
      .out_vld (chain_vld[ROOT_STEPS + DIV_BITS + k + 1]),
      .out_item(chain_item[ROOT_STEPS + DIV_BITS + k + 1])
    );
  end

  chsbs_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (chain_vld[CHAIN]),
    .in_item(chain_item[CHAIN]),
    .out_vld(m_tvalid),
    .alive  (m_tuser),
    .dir    (res_dir),
    .color  (res_col)
  );

  assign m_tdata = {res_col[2], res_col[1], res_col[0],
                    res_dir[2], res_dir[1], res_dir[0]};

endmodule
